@@ hdl/assert_macros.svh @@
// Assertion macros for the checker file of the tile collision block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define TMCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define TMCR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/tmcr_pkg.sv @@
// Shared types, constants and defaults of the tile map collision block.
`default_nettype none

package tmcr_pkg;

  // field widths
  localparam int POS_W      = 18;
  localparam int TILE_IN_W  = 6;
  localparam int CHAR_W     = 8;
  localparam int CFG_W      = 7;
  localparam int TIDX_W     = 8;   // holds a tile index up to 255
  localparam int NCORNER    = 4;
  localparam int CNT_W      = 3;   // 0..4 recorded tiles

  localparam int POS_MAX_C  = 131071;
  localparam int POS_MIN_C  = -131072;

  localparam logic [CHAR_W-1:0] FREE_CHAR = 8'h2E;   // '.'

  // request types
  localparam logic REQ_MAP_WRITE = 1'b0;
  localparam logic REQ_COLLIDE   = 1'b1;

  // config port
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;
  localparam logic REG_MAP_COLS = 1'b0;
  localparam logic REG_MAP_ROWS = 1'b1;
  localparam logic [CFG_W-1:0] MAP_COLS_RST = 7'd64;
  localparam logic [CFG_W-1:0] MAP_ROWS_RST = 7'd64;

  // parameter defaults
  localparam int MAP_COLS_MAX_DEF = 64;
  localparam int MAP_ROWS_MAX_DEF = 64;
  localparam int TILE_SIZE_DEF    = 64;
  localparam int AGENT_SIZE_DEF   = 60;
  localparam int AGENT_HALF_DEF   = 30;
  localparam int FRAC_BITS_DEF    = 4;

  localparam int QUEUE_DEPTH = 2;

  // one classified collide job, front to back
  typedef struct packed {
    logic signed [POS_W-1:0]            pos_x;
    logic signed [POS_W-1:0]            pos_y;
    logic [CNT_W-1:0]                   hit_count;
    logic [NCORNER-1:0][TIDX_W-1:0]     col;
    logic [NCORNER-1:0][TIDX_W-1:0]     row;
  } job_t;

endpackage

`default_nettype wire

@@ hdl/tmcr_queue.sv @@
// Small FIFO of collide jobs between front and back.
`default_nettype none

module tmcr_queue import tmcr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  job_t push_job,
  output logic full,
  output logic head_valid,
  output job_t head_job,
  input  logic pop
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t            slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign full       = (count_r == CW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tmcr_front.sv @@
// Front end: accepts items, holds the tile map, finds blocked corner tiles.
`default_nettype none

module tmcr_front import tmcr_pkg::*; #(
  parameter int MAP_COLS_MAX = MAP_COLS_MAX_DEF,
  parameter int MAP_ROWS_MAX = MAP_ROWS_MAX_DEF,
  parameter int TILE_SIZE    = TILE_SIZE_DEF,
  parameter int AGENT_SIZE   = AGENT_SIZE_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    req_type,
  input  logic [TILE_IN_W-1:0]    tile_row,
  input  logic [TILE_IN_W-1:0]    tile_col,
  input  logic [CHAR_W-1:0]       tile_char,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic [CFG_W-1:0]        map_cols,
  input  logic [CFG_W-1:0]        map_rows,
  output logic                    push_valid,
  output job_t                    push_job,
  input  logic                    queue_full
);

  localparam int SPAN   = TILE_SIZE << FRAC_BITS;
  localparam int SIZE_U = AGENT_SIZE << FRAC_BITS;
  localparam int CW     = $clog2((1 << (POS_W - 1)) + SIZE_U);  // corner magnitude
  localparam int SW     = CW + 1;                               // signed corner
  localparam int K      = CW + $clog2(SPAN);
  localparam int PW     = 2 * CW + 1;
  localparam longint unsigned RECIP_L = (64'd1 << K) / SPAN;
  localparam logic [CW:0] RECIP = RECIP_L[CW:0];
  localparam int DEPTH  = MAP_ROWS_MAX * MAP_COLS_MAX;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    F_IDLE, F_DIV1, F_DIV2, F_READ, F_DRAIN, F_PUSH
  } fstate_t;

  fstate_t               state_r, state_nxt;
  logic signed [SW-1:0]  corner_r [NCORNER], corner_nxt [NCORNER];  // x0 x1 y0 y1
  logic [CW-1:0]         q_r [NCORNER], q_nxt [NCORNER];
  logic [1:0]            rd_k_r, rd_k_nxt;
  logic                  pend_r, pend_nxt;
  logic [1:0]            pend_k_r, pend_k_nxt;
  job_t                  job_r, job_nxt;

  logic                  mem [DEPTH];
  logic                  rd_bit_r;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic                  wr_bit;

  logic                  in_accept;
  logic [1:0]            xin;
  logic [1:0]            yin;
  logic [CW-1:0]         mag [NCORNER];
  logic [PW-1:0]         prod [NCORNER];
  logic [PW-1:0]         prod_sh [NCORNER];
  logic [PW-1:0]         mq [NCORNER];
  logic [CW-1:0]         rem [NCORNER];
  logic [TIDX_W-1:0]     rd_col;
  logic [TIDX_W-1:0]     rd_row;
  logic [TIDX_W-1:0]     pend_col;
  logic [TIDX_W-1:0]     pend_row;
  logic [1:0]            slot;

  assign in_stall   = (state_r != F_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign push_valid = (state_r == F_PUSH);
  assign push_job   = job_r;

  // map write address and value
  assign wr_addr = AW'({26'b0, tile_row} * MAP_COLS_MAX + {26'b0, tile_col});
  assign wr_bit  = (tile_char != FREE_CHAR);

  // tile divide: reciprocal multiply, then one correction step
  always_comb begin
    for (int j = 0; j < NCORNER; j++) begin
      mag[j]     = corner_r[j][CW-1:0];
      prod[j]    = {{(CW+1){1'b0}}, mag[j]} * {{CW{1'b0}}, RECIP};
      prod_sh[j] = prod[j] >> K;
      mq[j]      = {{(CW+1){1'b0}}, q_r[j]} * PW'(SPAN);
      rem[j]     = mag[j] - mq[j][CW-1:0];
    end
  end

  // in-map tests per axis, lanes 0/1 are x, 2/3 are y
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      xin[j] = !corner_r[j][SW-1] && (q_r[j] < CW'(map_cols))
               && (q_r[j] < CW'(MAP_COLS_MAX));
      yin[j] = !corner_r[j+2][SW-1] && (q_r[j+2] < CW'(map_rows))
               && (q_r[j+2] < CW'(MAP_ROWS_MAX));
    end
  end

  // corner order TL TR BL BR: bit 0 picks the x lane, bit 1 the y lane
  assign rd_col   = q_r[{1'b0, rd_k_r[0]}][TIDX_W-1:0];
  assign rd_row   = q_r[{1'b1, rd_k_r[1]}][TIDX_W-1:0];
  assign rd_addr  = AW'({24'b0, rd_row} * MAP_COLS_MAX + {24'b0, rd_col});
  assign pend_col = q_r[{1'b0, pend_k_r[0]}][TIDX_W-1:0];
  assign pend_row = q_r[{1'b1, pend_k_r[1]}][TIDX_W-1:0];
  assign slot     = job_r.hit_count[1:0];

  always_comb begin
    state_nxt  = state_r;
    corner_nxt = corner_r;
    q_nxt      = q_r;
    rd_k_nxt   = rd_k_r;
    pend_nxt   = 1'b0;
    pend_k_nxt = pend_k_r;
    job_nxt    = job_r;
    rd_en      = 1'b0;
    wr_en      = 1'b0;

    // record the corner whose map bit came back this cycle
    if (pend_r && xin[pend_k_r[0]] && yin[pend_k_r[1]] && rd_bit_r) begin
      job_nxt.col[slot] = pend_col;
      job_nxt.row[slot] = pend_row;
      job_nxt.hit_count = job_r.hit_count + 1'b1;
    end

    case (state_r)
      F_IDLE: begin
        if (in_accept) begin
          if (req_type == REQ_MAP_WRITE) begin
            wr_en = ({26'b0, tile_row} < MAP_ROWS_MAX) && ({26'b0, tile_col} < MAP_COLS_MAX);
          end else begin
            corner_nxt[0]     = SW'(pos_x);
            corner_nxt[1]     = SW'(pos_x) + SW'(SIZE_U);
            corner_nxt[2]     = SW'(pos_y);
            corner_nxt[3]     = SW'(pos_y) + SW'(SIZE_U);
            job_nxt.pos_x     = pos_x;
            job_nxt.pos_y     = pos_y;
            job_nxt.hit_count = '0;
            state_nxt         = F_DIV1;
          end
        end
      end
      F_DIV1: begin
        for (int j = 0; j < NCORNER; j++) begin
          q_nxt[j] = prod_sh[j][CW-1:0];
        end
        state_nxt = F_DIV2;
      end
      F_DIV2: begin
        for (int j = 0; j < NCORNER; j++) begin
          q_nxt[j] = q_r[j] + CW'({1'b0, rem[j]} >= (CW+1)'(SPAN));
        end
        rd_k_nxt  = '0;
        state_nxt = F_READ;
      end
      F_READ: begin
        rd_en      = xin[rd_k_r[0]] && yin[rd_k_r[1]];
        pend_nxt   = 1'b1;
        pend_k_nxt = rd_k_r;
        rd_k_nxt   = rd_k_r + 1'b1;
        if (rd_k_r == 2'd3) begin
          state_nxt = F_DRAIN;
        end
      end
      F_DRAIN: begin
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!queue_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
    corner_r <= corner_nxt;
    q_r      <= q_nxt;
    rd_k_r   <= rd_k_nxt;
    pend_k_r <= pend_k_nxt;
    job_r    <= job_nxt;
  end

  // tile map, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
    if (rd_en) begin
      rd_bit_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/tmcr_back.sv @@
// Back end: pushes the agent out of each recorded tile, drives the result.
`default_nettype none

module tmcr_back import tmcr_pkg::*; #(
  parameter int MAP_COLS_MAX = MAP_COLS_MAX_DEF,
  parameter int MAP_ROWS_MAX = MAP_ROWS_MAX_DEF,
  parameter int TILE_SIZE    = TILE_SIZE_DEF,
  parameter int AGENT_HALF   = AGENT_HALF_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    job_valid,
  input  job_t                    job,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] new_pos_x,
  output logic signed [POS_W-1:0] new_pos_y,
  output logic                    hit_wall
);

  localparam int SCALE = 1 << FRAC_BITS;
  localparam int TSPAN = TILE_SIZE * SCALE;
  localparam int MAXT  = (MAP_COLS_MAX > MAP_ROWS_MAX) ? MAP_COLS_MAX : MAP_ROWS_MAX;
  localparam int TMAX  = (2 * MAXT - 1) * TSPAN;
  localparam int AH2   = 2 * AGENT_HALF * SCALE;
  localparam int MIN2  = (2 * AGENT_HALF + TILE_SIZE) * SCALE;
  localparam int DW    = $clog2((1 << POS_W) + TMAX + AH2 + 1) + 1;   // doubled scale
  localparam logic signed [DW-1:0] AH2_D  = DW'(AH2);
  localparam logic signed [DW-1:0] MIN2_D = DW'(MIN2);
  localparam logic signed [DW-1:0] PMAX_D = DW'(POS_MAX_C);
  localparam logic signed [DW-1:0] PMIN_D = DW'(POS_MIN_C);

  typedef enum logic [2:0] {
    B_IDLE, B_DIST, B_DEPTH, B_MOVE, B_OUT
  } bstate_t;

  bstate_t                 state_r, state_nxt;
  job_t                    job_r, job_nxt;
  logic signed [POS_W-1:0] px_r, px_nxt;
  logic signed [POS_W-1:0] py_r, py_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic signed [DW-1:0]    dx2_r, dx2_nxt;
  logic signed [DW-1:0]    dy2_r, dy2_nxt;
  logic signed [DW-1:0]    xd2_r, xd2_nxt;
  logic signed [DW-1:0]    yd2_r, yd2_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [POS_W-1:0] out_x_r, out_x_nxt;
  logic signed [POS_W-1:0] out_y_r, out_y_nxt;
  logic                    out_hit_r, out_hit_nxt;

  logic signed [DW-1:0]    px2;
  logic signed [DW-1:0]    py2;
  logic signed [DW-1:0]    tx2;
  logic signed [DW-1:0]    ty2;
  logic signed [DW-1:0]    abs_x;
  logic signed [DW-1:0]    abs_y;
  logic                    use_x;
  logic signed [DW-1:0]    depth_sel;
  logic signed [DW-1:0]    half;
  logic signed [DW-1:0]    p_ext;
  logic signed [DW-1:0]    moved;
  logic signed [DW-1:0]    clamped;
  logic [CNT_W-1:0]        idx_inc;

  assign out_valid = out_valid_r;
  assign new_pos_x = out_x_r;
  assign new_pos_y = out_y_r;
  assign hit_wall  = out_hit_r;

  // distances at twice the scale so the half unit survives
  assign px2 = {{(DW-POS_W-1){px_r[POS_W-1]}}, px_r, 1'b0};
  assign py2 = {{(DW-POS_W-1){py_r[POS_W-1]}}, py_r, 1'b0};
  assign tx2 = DW'({{(31-TIDX_W){1'b0}}, job_r.col[idx_r[1:0]], 1'b1} * TSPAN);
  assign ty2 = DW'({{(31-TIDX_W){1'b0}}, job_r.row[idx_r[1:0]], 1'b1} * TSPAN);

  assign abs_x = dx2_r[DW-1] ? -dx2_r : dx2_r;
  assign abs_y = dy2_r[DW-1] ? -dy2_r : dy2_r;

  // push along the shallower axis, ties go to y, away from the tile center
  assign use_x     = (xd2_r < yd2_r);
  assign depth_sel = use_x ? xd2_r : yd2_r;
  assign half      = (depth_sel + DW'(1)) >>> 1;
  assign p_ext     = use_x ? DW'(px_r) : DW'(py_r);
  assign moved     = (use_x ? dx2_r[DW-1] : dy2_r[DW-1]) ? p_ext - half : p_ext + half;
  assign clamped   = (moved > PMAX_D) ? PMAX_D : ((moved < PMIN_D) ? PMIN_D : moved);
  assign idx_inc   = idx_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    idx_nxt       = idx_r;
    dx2_nxt       = dx2_r;
    dy2_nxt       = dy2_r;
    xd2_nxt       = xd2_r;
    yd2_nxt       = yd2_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_hit_nxt   = out_hit_r;
    pop           = 1'b0;

    case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          pop       = 1'b1;
          job_nxt   = job;
          px_nxt    = job.pos_x;
          py_nxt    = job.pos_y;
          idx_nxt   = '0;
          state_nxt = (job.hit_count == '0) ? B_OUT : B_DIST;
        end
      end
      B_DIST: begin
        dx2_nxt   = px2 + AH2_D - tx2;
        dy2_nxt   = py2 + AH2_D - ty2;
        state_nxt = B_DEPTH;
      end
      B_DEPTH: begin
        xd2_nxt   = MIN2_D - abs_x;
        yd2_nxt   = MIN2_D - abs_y;
        state_nxt = B_MOVE;
      end
      B_MOVE: begin
        if (xd2_r > 0 && yd2_r > 0) begin
          if (use_x) begin
            px_nxt = clamped[POS_W-1:0];
          end else begin
            py_nxt = clamped[POS_W-1:0];
          end
        end
        idx_nxt   = idx_inc;
        state_nxt = (idx_inc == job_r.hit_count) ? B_OUT : B_DIST;
      end
      B_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = px_r;
          out_y_nxt     = py_r;
          out_hit_nxt   = (job_r.hit_count != '0);
          state_nxt     = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r     <= job_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    idx_r     <= idx_nxt;
    dx2_r     <= dx2_nxt;
    dy2_r     <= dy2_nxt;
    xd2_r     <= xd2_nxt;
    yd2_r     <= yd2_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_hit_r <= out_hit_nxt;
  end

endmodule

`default_nettype wire

@@ hdl/tile_map_collision_resolve.sv @@
// Top level of the tile map collision block: config registers and the pipeline.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   in      | in        | in_valid / in_stall  | req_type tile_row tile_col tile_char pos_x/y
//   out     | out       | out_valid / out_stall| new_pos_x new_pos_y hit_wall
//   config  | in        | psel penable pwrite  | paddr pwdata prdata, pready tied high
//
// A map write causes no result. A collide transfer occupies the front through the accept,
// two divide steps (reciprocal multiply and correction), four corner reads on the single map
// port, one drain and the queue hand-off, which waits while the queue is full. The back
// runs one distance, depth and move step for each recorded tile; the front takes a new
// transfer once it has handed the last one to the queue, while the back works on older ones.
// Reset brings map_cols and map_rows to 64; the tile map holds no reset and is not cleared.
// A two-entry job queue lets the front keep taking transfers while the back or a stalled
// result holds; in_stall is high whenever the front is busy, also while it waits on a full queue.
`default_nettype none

module tile_map_collision_resolve import tmcr_pkg::*; #(
  parameter int MAP_COLS_MAX = MAP_COLS_MAX_DEF,
  parameter int MAP_ROWS_MAX = MAP_ROWS_MAX_DEF,
  parameter int TILE_SIZE    = TILE_SIZE_DEF,
  parameter int AGENT_SIZE   = AGENT_SIZE_DEF,
  parameter int AGENT_HALF   = AGENT_HALF_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_req_type,
  input  logic [TILE_IN_W-1:0]    in_tile_row,
  input  logic [TILE_IN_W-1:0]    in_tile_col,
  input  logic [CHAR_W-1:0]       in_tile_char,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] out_new_pos_x,
  output logic signed [POS_W-1:0] out_new_pos_y,
  output logic                    out_hit_wall,
  // config port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready
);

  logic [CFG_W-1:0] map_cols_r, map_cols_nxt;
  logic [CFG_W-1:0] map_rows_r, map_rows_nxt;
  logic             cfg_write;
  logic             reg_sel;

  logic             push_valid;
  job_t             push_job;
  logic             queue_full;
  logic             head_valid;
  job_t             head_job;
  logic             pop;

  // config registers at byte 0 (map_cols) and byte 4 (map_rows)
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = paddr[2];

  always_comb begin
    map_cols_nxt = map_cols_r;
    map_rows_nxt = map_rows_r;
    if (cfg_write) begin
      case (reg_sel)
        REG_MAP_COLS: map_cols_nxt = pwdata[CFG_W-1:0];
        REG_MAP_ROWS: map_rows_nxt = pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MAP_COLS: prdata = {{(APB_DW-CFG_W){1'b0}}, map_cols_r};
      REG_MAP_ROWS: prdata = {{(APB_DW-CFG_W){1'b0}}, map_rows_r};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_cols_r <= MAP_COLS_RST;
      map_rows_r <= MAP_ROWS_RST;
    end else begin
      map_cols_r <= map_cols_nxt;
      map_rows_r <= map_rows_nxt;
    end
  end

  // front: map writes and corner classification
  tmcr_front #(
    .MAP_COLS_MAX (MAP_COLS_MAX),
    .MAP_ROWS_MAX (MAP_ROWS_MAX),
    .TILE_SIZE    (TILE_SIZE),
    .AGENT_SIZE   (AGENT_SIZE),
    .FRAC_BITS    (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (in_req_type),
    .tile_row   (in_tile_row),
    .tile_col   (in_tile_col),
    .tile_char  (in_tile_char),
    .pos_x      (in_pos_x),
    .pos_y      (in_pos_y),
    .map_cols   (map_cols_r),
    .map_rows   (map_rows_r),
    .push_valid (push_valid),
    .push_job   (push_job),
    .queue_full (queue_full)
  );

  tmcr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  // back: push-out steps and the result register
  tmcr_back #(
    .MAP_COLS_MAX (MAP_COLS_MAX),
    .MAP_ROWS_MAX (MAP_ROWS_MAX),
    .TILE_SIZE    (TILE_SIZE),
    .AGENT_HALF   (AGENT_HALF),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (head_valid),
    .job       (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .new_pos_x (out_new_pos_x),
    .new_pos_y (out_new_pos_y),
    .hit_wall  (out_hit_wall)
  );

endmodule

`default_nettype wire

@@ hdl/tmcr_checker.sv @@
// Port-level checker of the tile map collision block and its bind.
`default_nettype none
`include "assert_macros.svh"

module tmcr_checker import tmcr_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    in_req_type,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [POS_W-1:0] out_new_pos_x,
  input logic signed [POS_W-1:0] out_new_pos_y,
  input logic                    out_hit_wall
);

  // front, queue, back and result register hold at most this many collides
  localparam logic [2:0] PEND_MAX = 3'd5;

  logic [2:0] pend_r;
  logic       coll_xfer;
  logic       out_xfer;

  assign coll_xfer = in_valid && !in_stall && (in_req_type == REQ_COLLIDE);
  assign out_xfer  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {2'b0, coll_xfer} - {2'b0, out_xfer};
    end
  end

  `TMCR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `TMCR_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_new_pos_x) && $stable(out_new_pos_y) && $stable(out_hit_wall), "stalled result changed")
  `TMCR_ASSERT(a_no_orphan, out_xfer |-> pend_r != 3'd0, "result without a collide transfer")
  `TMCR_ASSERT(a_pend_bound, pend_r <= PEND_MAX, "too many collides in flight")
  `TMCR_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind tile_map_collision_resolve tmcr_checker u_tmcr_checker (.*);

`default_nettype wire
